/* rtl/pidc_pkg.sv */
// shared constants, types and state codes for the pid controller step block
// no dependencies
package pidc_pkg;

  localparam int FRAC_BITS = 16;

  localparam int RAW_W  = 32;
  localparam int GAIN_W = 32;
  localparam int DT_W   = 16;
  localparam int DB_W   = 18;
  localparam int DRV_W  = 18;
  localparam int ERR_W  = 19;
  localparam int INT_W  = 48;
  localparam int DER_W  = 32;
  localparam int CFG_W  = 32;

  // divider: dividend holds |raw + offset| shifted up by FRAC_BITS+1
  localparam int DSR_W = RAW_W + 1;
  localparam int DVD_W = DSR_W + FRAC_BITS + 1;
  localparam int QUO_W = 33;

  // serial multiplier
  localparam int MPL_W = INT_W;
  localparam int ACC_W = 84;

  localparam logic signed [DRV_W-1:0] ONE_Q = DRV_W'(1 << FRAC_BITS);

  typedef enum logic [2:0] {
    CFG_GAIN_P,
    CFG_GAIN_I,
    CFG_GAIN_D,
    CFG_ENC_TOP,
    CFG_ENC_BOTTOM,
    CFG_DEADBAND,
    CFG_MAX_CHANGE,
    CFG_ENABLE
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DSP,
    ST_WSP,
    ST_DLT,
    ST_WLT,
    ST_DEN,
    ST_WEN,
    ST_MINT,
    ST_WINT,
    ST_DDER,
    ST_WDER,
    ST_MP,
    ST_WP,
    ST_MI,
    ST_WI,
    ST_MD,
    ST_WD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_res_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] acc;
  } mul_res_t;

endpackage

/* rtl/pidc_div.sv */
// restoring divider, one quotient bit per cycle, unsigned magnitudes
// depends on pidc_pkg
module pidc_div import pidc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output div_res_t         res
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, done_r, ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] dsr_r, rem_r;
  logic [QUO_W-1:0] quo_r;
  logic [DSR_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
      // sticky flag once the quotient no longer fits
      ovf_r <= ovf_r | quo_r[QUO_W-1];
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quo  = quo_r;

endmodule

/* rtl/pidc_mul.sv */
// shift-add multiplier, one multiplier bit per cycle, signed, accumulating
// depends on pidc_pkg
module pidc_mul import pidc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    clr,
  input  logic signed [ACC_W-1:0] mcand,
  input  logic signed [MPL_W-1:0] mplier,
  output mul_res_t                res
);

  localparam int CNT_W = $clog2(MPL_W);

  logic                    busy_r, done_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [ACC_W-1:0] mcand_r, acc_r, addend;
  logic [MPL_W-1:0]        mplier_r;

  // the top bit of the multiplier carries negative weight
  always_comb begin
    if (!mplier_r[0]) begin
      addend = '0;
    end else if (cnt_r == CNT_W'(MPL_W - 1)) begin
      addend = -mcand_r;
    end else begin
      addend = mcand_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(MPL_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= mcand;
      mplier_r <= mplier;
      cnt_r    <= '0;
      if (clr) begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      acc_r    <= acc_r + addend;
      mcand_r  <= mcand_r <<< 1;
      mplier_r <= {1'b0, mplier_r[MPL_W-1:1]};
      cnt_r    <= cnt_r + 1'b1;
    end
  end

  assign res.done = done_r;
  assign res.acc  = acc_r;

endmodule

/* rtl/pid_controller_step.sv */
// pid controller step: one transaction at a time, the input stays stalled until
// the result is registered at the output. up to four divisions (three scalings and
// the derivative) run on a one-bit-per-cycle divider, up to four products on a
// one-bit-per-cycle multiplier. synchronous active-low reset restores the
// register defaults, clears the loop state and marks a restart pending.
module pid_controller_step import pidc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [RAW_W-1:0]  in_encoder_value,
  input  logic signed [RAW_W-1:0]  in_target,
  input  logic [DT_W-1:0]          in_elapsed,
  input  logic                     in_clear_integral,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DRV_W-1:0]  out_drive,
  output logic signed [ERR_W-1:0]  out_prop_term,
  output logic signed [INT_W-1:0]  out_integ_term,
  output logic signed [DER_W-1:0]  out_deriv_term
);

  state_t state_r, state_nxt;

  // configuration
  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic signed [RAW_W-1:0]  enc_top_r, enc_bot_r;
  logic [DB_W-1:0]          deadband_r, max_change_r;
  logic                     enable_r;

  // loop state
  logic signed [INT_W-1:0]  integ_r;
  logic signed [ERR_W-1:0]  prev_err_r;
  logic signed [RAW_W-1:0]  last_tgt_r;
  logic                     first_r;

  // transaction
  logic signed [RAW_W-1:0]  enc_r, tgt_r;
  logic [DT_W-1:0]          dt_r;
  logic                     clr_r, dis_r, div_neg_r;
  logic signed [DRV_W-1:0]  sp_r, drive_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [DER_W-1:0]  deriv_r;

  logic                     out_valid_r;
  logic signed [DRV_W-1:0]  out_drive_r;
  logic signed [ERR_W-1:0]  out_prop_r;
  logic signed [INT_W-1:0]  out_integ_r;
  logic signed [DER_W-1:0]  out_deriv_r;

  // divider and multiplier hookup
  logic                    div_start, mul_start, mul_clr;
  logic [DVD_W-1:0]        div_dvd;
  logic [DSR_W-1:0]        div_dsr;
  logic                    div_neg;
  div_res_t                div_res;
  mul_res_t                mul_res;
  logic signed [ACC_W-1:0] mul_mcand;
  logic signed [MPL_W-1:0] mul_mplier;

  // scaling operands
  logic signed [RAW_W-1:0] scale_raw;
  logic signed [RAW_W+1:0] bot_x, off_x, span_x, num_x, num_abs, span_abs;
  logic                    span_zero;
  logic signed [ERR_W:0]   diff_w, diff_abs;

  // division results
  logic [QUO_W-1:0]        qmag;
  logic signed [QUO_W+1:0] qv, sv;
  logic signed [DRV_W-1:0] scaled_w;
  logic signed [DER_W-1:0] deriv_w;
  logic signed [ERR_W-1:0] err_w, jump_w, err_abs, jump_abs;
  logic                    jump_big, err_live;

  // multiply results
  logic signed [ACC_W-1:0] prod_sh, drv_sh;
  logic signed [INT_W:0]   integ_sum;
  logic signed [INT_W-1:0] integ_w;
  logic signed [DRV_W-1:0] drive_w;

  always_comb begin
    unique case (state_r)
      ST_DSP:  scale_raw = tgt_r;
      ST_DLT:  scale_raw = last_tgt_r;
      default: scale_raw = enc_r;
    endcase
  end

  assign bot_x     = (RAW_W+2)'(enc_bot_r);
  assign off_x     = bot_x[RAW_W+1] ? -bot_x : bot_x;
  assign span_x    = (RAW_W+2)'(enc_top_r) + off_x;
  assign num_x     = (RAW_W+2)'(scale_raw) + off_x;
  assign num_abs   = num_x[RAW_W+1] ? -num_x : num_x;
  assign span_abs  = span_x[RAW_W+1] ? -span_x : span_x;
  assign span_zero = (span_x == '0);

  assign diff_w   = (ERR_W+1)'(err_r) - (ERR_W+1)'(prev_err_r);
  assign diff_abs = diff_w[ERR_W] ? -diff_w : diff_w;

  always_comb begin
    if (state_r == ST_DDER) begin
      div_dvd = DVD_W'({diff_abs[ERR_W-1:0], DT_W'(0)});
      div_dsr = DSR_W'(dt_r);
      div_neg = diff_w[ERR_W];
    end else begin
      div_dvd = {num_abs[DSR_W-1:0], (FRAC_BITS+1)'(0)};
      div_dsr = span_abs[DSR_W-1:0];
      div_neg = num_x[RAW_W+1] ^ span_x[RAW_W+1];
    end
  end

  pidc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .res      (div_res)
  );

  // truncating quotient, saturated in magnitude
  assign qmag = div_res.ovf ? '1 : div_res.quo;
  assign qv   = div_neg_r ? -(QUO_W+2)'(qmag) : (QUO_W+2)'(qmag);
  assign sv   = qv - (QUO_W+2)'(ONE_Q);

  always_comb begin
    if (span_zero) begin
      scaled_w = '0;
    end else if (sv > (QUO_W+2)'(ONE_Q)) begin
      scaled_w = ONE_Q;
    end else if (sv < -(QUO_W+2)'(ONE_Q)) begin
      scaled_w = -ONE_Q;
    end else begin
      scaled_w = sv[DRV_W-1:0];
    end
  end

  always_comb begin
    if (qv > $signed((QUO_W+2)'({1'b0, {(DER_W-1){1'b1}}}))) begin
      deriv_w = {1'b0, {(DER_W-1){1'b1}}};
    end else if (qv < -$signed((QUO_W+2)'({1'b1, {(DER_W-1){1'b0}}}))) begin
      deriv_w = {1'b1, {(DER_W-1){1'b0}}};
    end else begin
      deriv_w = qv[DER_W-1:0];
    end
  end

  assign err_w    = ERR_W'(sp_r) - ERR_W'(scaled_w);
  assign jump_w   = ERR_W'(sp_r) - ERR_W'(scaled_w);
  assign err_abs  = err_w[ERR_W-1] ? -err_w : err_w;
  assign jump_abs = jump_w[ERR_W-1] ? -jump_w : jump_w;
  assign jump_big = jump_abs > ERR_W'(max_change_r);
  assign err_live = err_abs > ERR_W'(deadband_r);

  always_comb begin
    unique case (state_r)
      ST_MINT: begin
        mul_mcand  = ACC_W'(err_r);
        mul_mplier = MPL_W'(dt_r);
      end
      ST_MP: begin
        mul_mcand  = ACC_W'(gain_p_r);
        mul_mplier = MPL_W'(err_r);
      end
      ST_MI: begin
        mul_mcand  = ACC_W'(gain_i_r);
        mul_mplier = integ_r;
      end
      default: begin
        mul_mcand  = ACC_W'(gain_d_r);
        mul_mplier = MPL_W'(deriv_r);
      end
    endcase
  end

  pidc_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .clr    (mul_clr),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .res    (mul_res)
  );

  // elapsed time is in 1/65536 s, so the integral step drops 16 bits
  assign prod_sh   = mul_res.acc >>> DT_W;
  assign integ_sum = (INT_W+1)'(integ_r) + prod_sh[INT_W:0];

  always_comb begin
    if (integ_sum > $signed((INT_W+1)'({1'b0, {(INT_W-1){1'b1}}}))) begin
      integ_w = {1'b0, {(INT_W-1){1'b1}}};
    end else if (integ_sum < -$signed((INT_W+1)'({1'b1, {(INT_W-1){1'b0}}}))) begin
      integ_w = {1'b1, {(INT_W-1){1'b0}}};
    end else begin
      integ_w = integ_sum[INT_W-1:0];
    end
  end

  assign drv_sh = mul_res.acc >>> FRAC_BITS;

  always_comb begin
    if (drv_sh > ACC_W'(ONE_Q)) begin
      drive_w = ONE_Q;
    end else if (drv_sh < -ACC_W'(ONE_Q)) begin
      drive_w = -ONE_Q;
    end else begin
      drive_w = drv_sh[DRV_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    mul_start = 1'b0;
    mul_clr   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DSP;
      end
      ST_DSP: begin
        div_start = 1'b1;
        state_nxt = ST_WSP;
      end
      ST_WSP: begin
        if (div_res.done) state_nxt = ST_DLT;
      end
      ST_DLT: begin
        div_start = 1'b1;
        state_nxt = ST_WLT;
      end
      ST_WLT: begin
        if (div_res.done) state_nxt = enable_r ? ST_DEN : ST_DONE;
      end
      ST_DEN: begin
        div_start = 1'b1;
        state_nxt = ST_WEN;
      end
      ST_WEN: begin
        if (div_res.done) begin
          priority if (err_live) state_nxt = ST_MINT;
          else if (dt_r == '0)   state_nxt = ST_MP;
          else                   state_nxt = ST_DDER;
        end
      end
      ST_MINT: begin
        mul_start = 1'b1;
        mul_clr   = 1'b1;
        state_nxt = ST_WINT;
      end
      ST_WINT: begin
        if (mul_res.done) state_nxt = (dt_r == '0) ? ST_MP : ST_DDER;
      end
      ST_DDER: begin
        div_start = 1'b1;
        state_nxt = ST_WDER;
      end
      ST_WDER: begin
        if (div_res.done) state_nxt = ST_MP;
      end
      ST_MP: begin
        mul_start = 1'b1;
        mul_clr   = 1'b1;
        state_nxt = ST_WP;
      end
      ST_WP: begin
        if (mul_res.done) state_nxt = ST_MI;
      end
      ST_MI: begin
        mul_start = 1'b1;
        state_nxt = ST_WI;
      end
      ST_WI: begin
        if (mul_res.done) state_nxt = ST_MD;
      end
      ST_MD: begin
        mul_start = 1'b1;
        state_nxt = ST_WD;
      end
      ST_WD: begin
        if (mul_res.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // configuration and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      enc_top_r    <= RAW_W'(4096);
      enc_bot_r    <= -RAW_W'(4096);
      deadband_r   <= '0;
      max_change_r <= DB_W'(655);
      enable_r     <= 1'b1;
      integ_r      <= '0;
      prev_err_r   <= '0;
      last_tgt_r   <= '0;
      first_r      <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_GAIN_P:     gain_p_r     <= cfg_wdata;
          CFG_GAIN_I:     gain_i_r     <= cfg_wdata;
          CFG_GAIN_D:     gain_d_r     <= cfg_wdata;
          CFG_ENC_TOP:    enc_top_r    <= cfg_wdata;
          CFG_ENC_BOTTOM: enc_bot_r    <= cfg_wdata;
          CFG_DEADBAND:   deadband_r   <= cfg_wdata[DB_W-1:0];
          CFG_MAX_CHANGE: max_change_r <= cfg_wdata[DB_W-1:0];
          CFG_ENABLE:     enable_r     <= cfg_wdata[0];
        endcase
      end
      if (state_r == ST_WLT && div_res.done) begin
        last_tgt_r <= tgt_r;
        // restart clears the integral only when the loop actually runs
        if (clr_r || (enable_r && (first_r || jump_big))) begin
          integ_r <= '0;
        end
        first_r <= enable_r ? 1'b0 : (first_r | jump_big);
      end
      if (state_r == ST_WINT && mul_res.done) begin
        integ_r <= integ_w;
      end
      if (state_r == ST_MP) begin
        prev_err_r <= err_r;
      end
    end
  end

  // transaction datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      enc_r <= in_encoder_value;
      tgt_r <= in_target;
      dt_r  <= in_elapsed;
      clr_r <= in_clear_integral;
    end
    if (div_start) begin
      div_neg_r <= div_neg;
    end
    if (state_r == ST_WSP && div_res.done) begin
      sp_r <= scaled_w;
    end
    if (state_r == ST_WLT && div_res.done) begin
      dis_r <= !enable_r;
    end
    if (state_r == ST_DEN) begin
      deriv_r <= '0;
    end
    if (state_r == ST_WEN && div_res.done) begin
      err_r <= err_w;
    end
    if (state_r == ST_WDER && div_res.done) begin
      deriv_r <= deriv_w;
    end
    if (state_r == ST_WD && mul_res.done) begin
      drive_r <= drive_w;
    end
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_drive_r <= dis_r ? '0 : drive_r;
      out_prop_r  <= dis_r ? '0 : err_r;
      out_integ_r <= dis_r ? '0 : integ_r;
      out_deriv_r <= dis_r ? '0 : deriv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_drive      = out_drive_r;
  assign out_prop_term  = out_prop_r;
  assign out_integ_term = out_integ_r;
  assign out_deriv_term = out_deriv_r;

endmodule

/* rtl/pidc_chk.sv */
// port-level checks for the pid controller step block, bound to the top level
// depends on pidc_pkg and pid_controller_step
module pidc_chk import pidc_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DRV_W-1:0]  out_drive
);

  // one transaction at a time: an accepted item keeps the input stalled
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transaction");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive <= ONE_Q) && (out_drive >= -ONE_Q))
    else $error("drive outside plus or minus one");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_drive_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_drive))
    else $error("drive changed while stalled");

endmodule

bind pid_controller_step pidc_chk u_pidc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_drive (out_drive)
);

/* test/testbench.sv */
// testbench for pid_controller_step: a predictor in a small scoreboard class checks
// every result transaction field by field under random idling on both channels
// depends on rtl/pidc_pkg.sv and rtl/pid_controller_step.sv
`timescale 1ns / 100ps

module testbench;
  import pidc_pkg::*;

  typedef struct {
    logic signed [RAW_W-1:0] enc;
    logic signed [RAW_W-1:0] tgt;
    logic [DT_W-1:0]         dt;
    logic                    clr;
  } step_in_t;

  typedef struct {
    logic signed [DRV_W-1:0] drive;
    logic signed [ERR_W-1:0] prop;
    logic signed [INT_W-1:0] integ;
    logic signed [DER_W-1:0] deriv;
  } step_out_t;

  class pid_scoreboard;
    longint kp, ki, kd, enc_top, enc_bot, deadband, max_jump, run_en;
    longint integ_acc, prev_err, last_tgt;
    bit restart;
    step_out_t expected_q[$];
    int errors;

    function void clear_state();
      kp = 0; ki = 0; kd = 0; enc_top = 4096; enc_bot = -4096;
      deadband = 0; max_jump = 655; run_en = 1;
      integ_acc = 0; prev_err = 0; last_tgt = 0; restart = 1;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_GAIN_P:     kp = longint'($signed(v));
        CFG_GAIN_I:     ki = longint'($signed(v));
        CFG_GAIN_D:     kd = longint'($signed(v));
        CFG_ENC_TOP:    enc_top = longint'($signed(v));
        CFG_ENC_BOTTOM: enc_bot = longint'($signed(v));
        CFG_DEADBAND:   deadband = longint'(v[DB_W-1:0]);
        CFG_MAX_CHANGE: max_jump = longint'(v[DB_W-1:0]);
        CFG_ENABLE:     run_en = longint'(v[0]);
        default: ;
      endcase
    endfunction

    function longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function longint to_unit(longint raw);
      longint off, span, one, s;
      one = longint'(1) <<< FRAC_BITS;
      off = enc_bot < 0 ? -enc_bot : enc_bot;
      span = enc_top + off;
      if (span == 0) return 0;
      s = ((raw + off) * (one * 2)) / span - one;
      return clip(s, -one, one);
    endfunction

    function void note_input(step_in_t it);
      longint one, sp, jump, err, d, hsum, lsum, carry, drv, bh, bl;
      longint imax, dmin, dmax;
      longint g[3], v[3];
      step_out_t r;
      one = longint'(1) <<< FRAC_BITS;
      imax = (longint'(1) <<< 47) - 1;
      dmax = 64'sd2147483647;
      dmin = -64'sd2147483648;
      sp = to_unit(longint'(it.tgt));
      jump = sp - to_unit(last_tgt);
      if (jump < 0) jump = -jump;
      if (jump > max_jump) restart = 1;
      last_tgt = longint'(it.tgt);
      if (it.clr) integ_acc = 0;
      if (run_en == 0) begin
        r = '{0, 0, 0, 0};
        expected_q.push_back(r);
        return;
      end
      if (restart) begin
        integ_acc = 0;
        restart = 0;
      end
      err = sp - to_unit(longint'(it.enc));
      if ((err < 0 ? -err : err) > deadband)
        integ_acc = clip(integ_acc + ((err * longint'(it.dt)) >>> 16), -imax - 1, imax);
      if (it.dt == 0) d = 0;
      else d = clip(((err - prev_err) * 65536) / longint'(it.dt), dmin, dmax);
      prev_err = err;
      // exact sum of products split at bit 24
      g[0] = kp; g[1] = ki; g[2] = kd;
      v[0] = err; v[1] = integ_acc; v[2] = d;
      hsum = 0; lsum = 0;
      for (int i = 0; i < 3; i++) begin
        bh = v[i] >>> 24;
        bl = v[i] - (bh <<< 24);
        hsum += g[i] * bh;
        lsum += g[i] * bl;
      end
      carry = lsum >>> 24;
      hsum += carry;
      lsum -= carry <<< 24;
      if (hsum >= one) drv = one;
      else if (hsum < -one) drv = -one;
      else drv = clip(hsum * (longint'(1) <<< (24 - FRAC_BITS)) + (lsum >>> FRAC_BITS),
                      -one, one);
      r.drive = DRV_W'(drv);
      r.prop  = ERR_W'(err);
      r.integ = INT_W'(integ_acc);
      r.deriv = DER_W'(d);
      expected_q.push_back(r);
    endfunction

    function void check_result(step_out_t act);
      step_out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction drive %0d", $time, act.drive);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (act.drive !== e.drive) begin
        $display("%0t: drive expected %0d actual %0d", $time, e.drive, act.drive);
        errors++;
      end
      if (act.prop !== e.prop) begin
        $display("%0t: prop_term expected %0d actual %0d", $time, e.prop, act.prop);
        errors++;
      end
      if (act.integ !== e.integ) begin
        $display("%0t: integ_term expected %0d actual %0d", $time, e.integ, act.integ);
        errors++;
      end
      if (act.deriv !== e.deriv) begin
        $display("%0t: deriv_term expected %0d actual %0d", $time, e.deriv, act.deriv);
        errors++;
      end
    endfunction
  endclass

  localparam int LIMIT = 2000000;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_valid, in_stall;
  logic signed [RAW_W-1:0] in_encoder_value, in_target;
  logic [DT_W-1:0] in_elapsed;
  logic in_clear_integral;
  logic out_valid, out_stall;
  logic signed [DRV_W-1:0] out_drive;
  logic signed [ERR_W-1:0] out_prop_term;
  logic signed [INT_W-1:0] out_integ_term;
  logic signed [DER_W-1:0] out_deriv_term;

  pid_controller_step dut (.*);

  pid_scoreboard sb;
  bit quiet;
  int cycles;
  int stall_left;
  longint top_r, bot_r, walk_tgt;

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver idling in bursts
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_drive, out_prop_term, out_integ_term, out_deriv_term});

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
    if (idx == CFG_ENC_TOP) top_r = longint'($signed(v));
    if (idx == CFG_ENC_BOTTOM) bot_r = longint'($signed(v));
  endtask

  task automatic send_item(step_in_t it);
    in_valid <= 1'b1;
    in_encoder_value <= it.enc;
    in_target <= it.tgt;
    in_elapsed <= it.dt;
    in_clear_integral <= it.clr;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_fields(longint e, longint t, int unsigned dt, bit c);
    step_in_t it;
    it.enc = RAW_W'(e);
    it.tgt = RAW_W'(t);
    it.dt = DT_W'(dt);
    it.clr = c;
    send_item(it);
  endtask

  // a point near the encoder range, a little beyond it now and then
  function automatic longint in_range();
    longint lo, hi, w;
    lo = bot_r;
    hi = top_r;
    if (hi < lo) begin
      lo = top_r;
      hi = bot_r;
    end
    w = hi - lo;
    return lo - w / 16 + longint'($urandom_range(0, 32'hffffffff)) % (w + w / 8 + 1);
  endfunction

  task automatic random_item();
    longint span, e;
    int unsigned dt;
    step_in_t it;
    span = top_r - bot_r;
    if (span < 0) span = -span;
    if ($urandom_range(0, 9) == 0) begin
      // noise transaction
      it.enc = $urandom;
      it.tgt = $urandom;
      it.dt = DT_W'($urandom);
      it.clr = 1'($urandom_range(0, 1));
      walk_tgt = longint'(it.tgt);
      send_item(it);
    end else begin
      // setpoint walk with small steps and a jump now and then
      if ($urandom_range(0, 11) == 0) walk_tgt = in_range();
      else walk_tgt += (longint'($urandom_range(0, 400)) - 200) * (span / 40000 + 1);
      e = walk_tgt + (longint'($urandom_range(0, 2000)) - 1000) * (span / 20000 + 1);
      case ($urandom_range(0, 3))
        0: dt = $urandom_range(0, 3);
        1: dt = $urandom;
        default: dt = $urandom_range(100, 2000);
      endcase
      send_fields(e, walk_tgt, dt, $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    top_r = 4096;
    bot_r = -4096;
    walk_tgt = 0;
    quiet = 0;
    cycles = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CFG_GAIN_P;
    cfg_wdata = '0;
    in_valid = 0;
    in_encoder_value = '0;
    in_target = '0;
    in_elapsed = '0;
    in_clear_integral = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: extremes of every field, first-step restart
    send_fields(0, 0, 0, 0);
    send_fields(-64'sd2147483648, 64'sd2147483647, 65535, 1);
    send_fields(64'sd2147483647, -64'sd2147483648, 1, 0);
    send_fields(4096, -4096, 65535, 0);
    send_fields(-4096, -4096, 300, 0);
    drain();

    write_reg(CFG_GAIN_P, 32'h0002_0000);
    write_reg(CFG_GAIN_I, 32'h0000_4000);
    write_reg(CFG_GAIN_D, 32'h0000_0100);
    write_reg(CFG_DEADBAND, 32'd200);
    send_fields(100, 200, 1000, 0);
    send_fields(50, 205, 1000, 0);
    send_fields(150, 203, 0, 0);
    send_fields(200, 203, 65535, 0);
    send_fields(200, 203, 1, 1);
    send_fields(-3000, 3000, 500, 0);
    send_fields(4096, 3000, 500, 0);
    drain();
    // disabled loop still tracks the setpoint
    write_reg(CFG_ENABLE, 32'd0);
    send_fields(10, 20, 500, 0);
    send_fields(10, -4000, 500, 1);
    drain();
    write_reg(CFG_ENABLE, 32'd1);
    send_fields(10, -4000, 500, 0);
    send_fields(10, -3990, 500, 0);
    drain();
    // zero span
    write_reg(CFG_ENC_TOP, 32'd0);
    write_reg(CFG_ENC_BOTTOM, 32'd0);
    send_fields(123, 456, 700, 0);
    send_fields(-5, 5, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_GAIN_P, 32'h0001_0000);
          write_reg(CFG_GAIN_I, 32'h0000_0800);
          write_reg(CFG_GAIN_D, 32'h0000_0040);
          write_reg(CFG_ENC_TOP, 32'd4096);
          write_reg(CFG_ENC_BOTTOM, -32'sd4096);
          write_reg(CFG_DEADBAND, 32'd0);
          write_reg(CFG_MAX_CHANGE, 32'd655);
        end
        1: begin
          write_reg(CFG_GAIN_P, 32'h7fff_ffff);
          write_reg(CFG_GAIN_I, 32'h8000_0000);
          write_reg(CFG_GAIN_D, 32'h7fff_ffff);
          write_reg(CFG_ENC_TOP, 32'h7fff_ffff);
          write_reg(CFG_ENC_BOTTOM, 32'h8000_0000);
          write_reg(CFG_DEADBAND, 32'd131072);
          write_reg(CFG_MAX_CHANGE, 32'd131072);
        end
        2: begin
          write_reg(CFG_GAIN_P, $urandom);
          write_reg(CFG_GAIN_I, $urandom);
          write_reg(CFG_GAIN_D, $urandom);
          write_reg(CFG_ENC_TOP, 32'd1000);
          write_reg(CFG_ENC_BOTTOM, 32'd200);
          write_reg(CFG_DEADBAND, $urandom_range(0, 3000));
          write_reg(CFG_MAX_CHANGE, 32'd0);
        end
        3: begin
          write_reg(CFG_GAIN_P, 32'hffff_0000);
          write_reg(CFG_GAIN_I, 32'h0000_0001);
          write_reg(CFG_GAIN_D, 32'h8000_0000);
          write_reg(CFG_ENC_TOP, -32'sd100);
          write_reg(CFG_ENC_BOTTOM, -32'sd50000);
          write_reg(CFG_ENABLE, 32'd0);
        end
        4: begin
          write_reg(CFG_GAIN_P, $urandom_range(0, 32'h0004_0000));
          write_reg(CFG_GAIN_I, $urandom_range(0, 32'h0001_0000));
          write_reg(CFG_GAIN_D, $urandom_range(0, 32'h0000_1000));
          write_reg(CFG_ENC_TOP, $urandom_range(1, 32'h00ff_ffff));
          write_reg(CFG_ENC_BOTTOM, -$urandom_range(0, 32'h00ff_ffff));
          write_reg(CFG_DEADBAND, $urandom_range(0, 500));
          write_reg(CFG_MAX_CHANGE, $urandom_range(100, 5000));
          write_reg(CFG_ENABLE, 32'd1);
        end
        default: begin
          write_reg(CFG_GAIN_P, 32'h0000_8000);
          write_reg(CFG_GAIN_I, 32'h0000_0400);
          write_reg(CFG_GAIN_D, 32'h0000_0020);
          write_reg(CFG_ENC_TOP, 32'd65535);
          write_reg(CFG_ENC_BOTTOM, 32'd0);
          write_reg(CFG_DEADBAND, 32'd10);
          write_reg(CFG_MAX_CHANGE, 32'd2000);
          write_reg(CFG_ENABLE, 32'd1);
        end
      endcase
      walk_tgt = (top_r + bot_r) / 2;
      for (int n = 0; n < 66; n++) begin
        if (ph == 5 && n == 6) quiet = 1;
        if (ph == 2 && n == 33) drain();
        random_item();
      end
      drain();
    end

    repeat (500) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
